FILE: rtl/hcbd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
package hcbd_pkg;

   localparam int SIZE_BITS = 32;
   localparam int BYTE_BITS = 8;
   localparam int KIND_BITS = 2;
   localparam int PHASE_BITS = 3;

   localparam logic [PHASE_BITS-1:0] PH_SIZE  = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_CR    = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_DATA  = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_SKIP1 = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_SKIP2 = 3'd4;

   localparam logic [KIND_BITS-1:0] KIND_DATA = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_END  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_OVF  = 2'd2;

   localparam logic [BYTE_BITS-1:0] CHAR_CR = 8'h0d;
   localparam logic [BYTE_BITS-1:0] CHAR_LF = 8'h0a;

   typedef logic [SIZE_BITS-1:0] size_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      size_type              size_accum;
      logic                  digits_done;
      size_type              bytes_left;
   } dec_state_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [BYTE_BITS-1:0] data_byte;
   } rsp_item_type;

   localparam dec_state_type STATE_RESET = '{
      phase:       PH_SIZE,
      size_accum:  '0,
      digits_done: 1'b0,
      bytes_left:  '0
   };

endpackage

FILE: rtl/hcbd_step.sv
// Per-byte decode step: next decoder state and the result item, if any.
module hcbd_step
   import hcbd_pkg::*;
(
   input  dec_state_type        cur_state,
   input  logic [BYTE_BITS-1:0] in_byte,
   output dec_state_type        next_state,
   output logic                 result_valid,
   output rsp_item_type         result
);

   logic       hex_ok;
   logic [3:0] hex_val;
   size_type   left_dec;

   always_comb begin
      hex_ok  = 1'b0;
      hex_val = 4'd0;
      if (in_byte inside {[8'h30:8'h39]}) begin
         hex_ok  = 1'b1;
         hex_val = in_byte[3:0];
      end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         hex_ok  = 1'b1;
         hex_val = in_byte[3:0] + 4'd9;
      end
   end

   assign left_dec = cur_state.bytes_left - size_type'(1);

   always_comb begin
      next_state   = cur_state;
      result_valid = 1'b0;
      result       = '{kind: KIND_DATA, data_byte: '0};
      case (cur_state.phase)
         PH_CR: begin
            if (in_byte == CHAR_LF) begin
               if (cur_state.size_accum == '0) begin
                  next_state   = STATE_RESET;
                  result_valid = 1'b1;
                  result.kind  = KIND_END;
               end else begin
                  next_state.bytes_left  = cur_state.size_accum;
                  next_state.size_accum  = '0;
                  next_state.digits_done = 1'b0;
                  next_state.phase       = PH_DATA;
               end
            end else if (in_byte != CHAR_CR) begin
               next_state.phase = PH_SIZE;
            end
         end
         PH_DATA: begin
            next_state.bytes_left = left_dec;
            if (left_dec == '0) begin
               next_state.phase = PH_SKIP1;
            end
            result_valid     = 1'b1;
            result.kind      = KIND_DATA;
            result.data_byte = in_byte;
         end
         PH_SKIP1: begin
            next_state.phase = PH_SKIP2;
         end
         PH_SKIP2: begin
            next_state.phase = PH_SIZE;
         end
         default: begin
            next_state.phase = PH_SIZE;
            if (!cur_state.digits_done && hex_ok) begin
               // a set top nibble means one more digit would not fit
               if (cur_state.size_accum[SIZE_BITS-1 -: 4] != 4'd0) begin
                  next_state   = STATE_RESET;
                  result_valid = 1'b1;
                  result.kind  = KIND_OVF;
               end else begin
                  next_state.size_accum = {cur_state.size_accum[SIZE_BITS-5:0], hex_val};
               end
            end else begin
               next_state.digits_done = 1'b1;
               if (in_byte == CHAR_CR) begin
                  next_state.phase = PH_CR;
               end
            end
         end
      endcase
   end

endmodule

FILE: rtl/http_chunked_body_decoder_core.sv
// HTTP/1.1 chunked body decoder: one body byte in, at most one result item out.
//
// Takes one body byte per clock on the req_ stream and keeps it going at one item per
// cycle for as long as the rsp_ side takes results; the decoder state is updated in the
// cycle an item is accepted, so the next byte may follow at once. A result goes to the
// result register, or to the skid register while rsp_ stalls. The output is a two-entry
// buffer (result register plus skid register), so req_tready drops only when both hold
// unsent items. Size line, CR/LF and chunk trailing bytes give no result; each payload
// byte gives a kind-0 item, a zero-size line a kind-1 end item, and a size beyond 32
// bits a kind-2 error item, after which the decoder starts over on a new body.
module http_chunked_body_decoder_core
   import hcbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] payload_byte
   output logic [1:0] rsp_tuser     // [1:0] result_kind
);

   dec_state_type state_ff, state_in;
   dec_state_type step_state;
   logic          step_valid;
   rsp_item_type  step_result;

   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_item_ff, out_item_in;
   logic          skid_valid_ff, skid_valid_in;
   rsp_item_type  skid_item_ff, skid_item_in;
   logic          req_fire;

   hcbd_step u_step (
      .cur_state    (state_ff),
      .in_byte      (req_tdata),
      .next_state   (step_state),
      .result_valid (step_valid),
      .result       (step_result)
   );

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      state_in      = req_fire ? step_state : state_ff;
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         // drain skid into the result register
         if (rsp_tready) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_fire && step_valid) begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_in = 1'b1;
            out_item_in  = step_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = step_result;
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_item_ff.data_byte;
   assign rsp_tuser  = out_item_ff.kind;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while result register is empty");

   a_data_has_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_DATA) |-> (state_ff.bytes_left != '0))
      else $error("payload phase with zero bytes left");

   a_chunk_clears_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_DATA || state_ff.phase == PH_SKIP1 ||
       state_ff.phase == PH_SKIP2) |-> (state_ff.size_accum == '0 && !state_ff.digits_done))
      else $error("size line state not cleared inside a chunk");

   a_marker_no_data: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.kind != KIND_DATA) |-> (out_item_ff.data_byte == '0))
      else $error("end or error item carries a nonzero byte");

   a_no_result_skip: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (state_ff.phase == PH_SKIP1 || state_ff.phase == PH_SKIP2))
      |=> ($stable(out_item_ff) || !out_valid_ff || $past(rsp_tready)))
      else $error("trailing byte produced a result");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the HTTP chunked body decoder core.
`timescale 1ns / 1ps

module tb_top;
   import hcbd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TARGET_ITEMS = 1550;
   localparam int MAX_PRINTED = 40;

   // Predicts decoder results from accepted body bytes and checks the rsp_ stream.
   class chunk_scoreboard;
      rsp_item_type          pending_results[$];
      logic [PHASE_BITS-1:0] phase;
      size_type              size_acc;
      bit                    digits_closed;
      size_type              left_count;
      int                    errors;
      int                    bytes_in;
      int                    payload_seen;
      int                    ends_seen;
      int                    overflows_seen;

      function new();
         restart();
      endfunction

      function void restart();
         phase = PH_SIZE;
         size_acc = '0;
         digits_closed = 1'b0;
         left_count = '0;
      endfunction

      function int hex_digit(input logic [7:0] b);
         if (b >= 8'h30 && b <= 8'h39) return int'(b) - 8'h30;
         if (b >= 8'h61 && b <= 8'h66) return int'(b) - 8'h61 + 10;
         if (b >= 8'h41 && b <= 8'h46) return int'(b) - 8'h41 + 10;
         return -1;
      endfunction

      // Advance the decoder state by one body byte; return 1 when it yields a result.
      function bit decode_byte(input logic [7:0] b, output rsp_item_type r);
         int v;
         r = '0;
         case (phase)
            PH_CR: begin
               if (b == CHAR_LF) begin
                  if (size_acc == '0) begin
                     restart();
                     r.kind = KIND_END;
                     return 1'b1;
                  end
                  left_count = size_acc;
                  size_acc = '0;
                  digits_closed = 1'b0;
                  phase = PH_DATA;
               end else if (b != CHAR_CR) begin
                  phase = PH_SIZE;
               end
               return 1'b0;
            end
            PH_DATA: begin
               left_count = left_count - 1'b1;
               if (left_count == '0) phase = PH_SKIP1;
               r.kind = KIND_DATA;
               r.data_byte = b;
               return 1'b1;
            end
            PH_SKIP1: begin
               phase = PH_SKIP2;
               return 1'b0;
            end
            PH_SKIP2: begin
               phase = PH_SIZE;
               return 1'b0;
            end
            default: begin
               v = hex_digit(b);
               phase = PH_SIZE;
               if (!digits_closed && v >= 0) begin
                  // a nonzero top nibble means the next digit cannot fit
                  if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
                     restart();
                     r.kind = KIND_OVF;
                     return 1'b1;
                  end
                  size_acc = {size_acc[SIZE_BITS-5:0], 4'(v)};
                  return 1'b0;
               end
               digits_closed = 1'b1;
               if (b == CHAR_CR) phase = PH_CR;
               return 1'b0;
            end
         endcase
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("ERROR: %s", msg);
      endtask

      task note_byte(input logic [7:0] b);
         rsp_item_type r;
         bytes_in++;
         if (decode_byte(b, r)) pending_results.push_back(r);
      endtask

      task check_result(input logic [KIND_BITS-1:0] kind, input logic [BYTE_BITS-1:0] data);
         rsp_item_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result kind %0d byte %02h with nothing expected", kind, data));
            return;
         end
         want = pending_results.pop_front();
         if (kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", kind, want.kind));
         if (data !== want.data_byte)
            report($sformatf("byte %02h, expected %02h (kind %0d)", data, want.data_byte,
                             want.kind));
         case (want.kind)
            KIND_DATA: payload_seen++;
            KIND_END:  ends_seen++;
            default:   overflows_seen++;
         endcase
      endtask

      function int pending();
         return pending_results.size();
      endfunction

      task close_out();
         while (pending_results.size() != 0) begin
            report($sformatf("result kind %0d never arrived", pending_results[0].kind));
            void'(pending_results.pop_front());
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] payload_byte
   logic [1:0] rsp_tuser;           // [1:0] result_kind

   chunk_scoreboard sb = new();
   logic [7:0]      body_stream[$];
   bit              no_idle = 1'b0;
   int              cycles = 0;

   http_chunked_body_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("ERROR: no finish after %0d cycles", CYCLE_LIMIT);
         $display("http_chunked_body_decoder_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 12);
   end

   // Check results before noting the byte taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
         if (req_tvalid && req_tready) sb.note_byte(req_tdata);
      end
   end

   function automatic logic [7:0] hex_char(input int unsigned d, input bit upper);
      if (d < 10) return 8'(8'h30 + d);
      return 8'((upper ? 8'h41 : 8'h61) + d - 10);
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) body_stream.push_back(s[i]);
   endtask

   task automatic push_size(input int unsigned value, input int zeros);
      int n;
      bit upper;
      n = 1;
      upper = $urandom_range(0, 1);
      while (n < 8 && (value >> (4 * n)) != 0) n++;
      repeat (zeros) body_stream.push_back(8'h30);
      for (int i = n - 1; i >= 0; i--) body_stream.push_back(hex_char((value >> (4 * i)) & 15,
                                                                      upper));
   endtask

   // Finish a size line: optional extension, optional stray CR, then CRLF.
   task automatic push_line_end();
      logic [7:0] b;
      if ($urandom_range(0, 3) == 0) begin
         body_stream.push_back(8'h3b);
         repeat ($urandom_range(1, 6)) begin
            b = 8'($urandom_range(0, 255));
            body_stream.push_back(b == CHAR_CR ? 8'h66 : b);
         end
      end
      case ($urandom_range(0, 11))
         0: begin
            b = 8'($urandom_range(0, 255));
            body_stream.push_back(CHAR_CR);
            body_stream.push_back((b == CHAR_CR || b == CHAR_LF) ? 8'h41 : b);
         end
         1: body_stream.push_back(CHAR_CR);
         default: ;
      endcase
      body_stream.push_back(CHAR_CR);
      body_stream.push_back(CHAR_LF);
   endtask

   task automatic push_body();
      int unsigned chunk_len;
      if ($urandom_range(0, 14) == 0)
         repeat ($urandom_range(1, 6)) body_stream.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 4)) begin
         chunk_len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300)
                                                  : $urandom_range(1, 24);
         push_size(chunk_len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
         push_line_end();
         repeat (chunk_len) body_stream.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 5) == 0) begin
            body_stream.push_back(8'($urandom_range(0, 255)));
            body_stream.push_back(8'($urandom_range(0, 255)));
         end else begin
            push_text("\r\n");
         end
      end
      // Abort some bodies with a size line one digit too long.
      if ($urandom_range(0, 11) == 0) begin
         body_stream.push_back(hex_char($urandom_range(1, 15), $urandom_range(0, 1)));
         repeat (8) body_stream.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
         push_text("\r\n");
         return;
      end
      case ($urandom_range(0, 3))
         0: ;
         1: push_text("000");
         default: push_text("0");
      endcase
      push_line_end();
      case ($urandom_range(0, 5))
         0, 1: push_text("\r\n");
         2: push_text("X-T: 1\r\n\r\n");
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [7:0] b);
      if (!no_idle && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold the sender until every expected result has come out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int directed_len;
      int half;

      // hex after an extension, CR without LF, CR CR LF, extreme payload bytes
      push_text("2;f\rZ\r\r\n");
      body_stream.push_back(8'h00);
      body_stream.push_back(8'hff);
      push_text("\r\n");
      // size overflow on the ninth digit, then an empty size line
      push_text("1A0000000\r\n");
      directed_len = body_stream.size();
      while (body_stream.size() < TARGET_ITEMS) push_body();
      // largest size that fits: the run ends partway through its payload
      push_text("FFFFffff\r\n");
      repeat (16) body_stream.push_back(8'($urandom_range(0, 255)));
      half = directed_len + (body_stream.size() - directed_len) / 2;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < body_stream.size(); i++) begin
         if (i == directed_len || i == half) drain_results();
         no_idle = (i >= directed_len + 500 && i < directed_len + 800);
         send_item(body_stream[i]);
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      sb.close_out();

      $display("covered %0d body bytes: %0d payload bytes, %0d body ends, %0d size overflows",
               sb.bytes_in, sb.payload_seen, sb.ends_seen, sb.overflows_seen);
      $display("with stray CRs, extensions, dropped trailers and random stalls on both sides");
      if (sb.errors == 0) begin
         $display("http_chunked_body_decoder_core: match");
      end else begin
         $display("http_chunked_body_decoder_core: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/hcbd_pkg.sv
rtl/hcbd_step.sv
rtl/http_chunked_body_decoder_core.sv
tb/tb_top.sv
